// ===== hw/rtl/fdd_pkg.sv =====
// ----------------------------------------------------------------------------
// fdd_pkg
// Shared widths, constants and types of the frame difference event detector.
// ----------------------------------------------------------------------------
package fdd_pkg;

	localparam int PIXEL_W = 8;
	localparam int COUNT_W = 17;
	localparam int THR_W   = 7;
	localparam int PROD_W  = 24;

	localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;
	localparam logic [THR_W-1:0]   THR_RESET     = 7'd5;
	localparam logic [THR_W-1:0]   PERCENT_SCALE = 7'd100;

	typedef logic [PIXEL_W-1:0] pixel_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [THR_W-1:0]   thr_t;
	typedef logic [PROD_W-1:0]  prod_t;

	typedef struct packed {
		logic   last;
		logic   report;
		count_t count;
	} frame_end_t;

endpackage

// ===== hw/rtl/fdd_pix_if.sv =====
// ----------------------------------------------------------------------------
// fdd_pix_if
// Pixel stream channel: one grey pixel and its end-of-frame mark per item.
// ----------------------------------------------------------------------------
interface fdd_pix_if;
	import fdd_pkg::*;

	logic   valid;
	logic   ready;
	pixel_t pixel;
	logic   last_pixel;

	modport source (output valid, output pixel, output last_pixel, input ready);
	modport sink (input valid, input pixel, input last_pixel, output ready);

endinterface

// ===== hw/rtl/fdd_res_if.sv =====
// ----------------------------------------------------------------------------
// fdd_res_if
// Result channel: one frame report per item.
// ----------------------------------------------------------------------------
interface fdd_res_if;
	import fdd_pkg::*;

	logic   valid;
	logic   ready;
	logic   event_res;
	count_t changed_count;
	count_t average_count;

	modport source (output valid, output event_res, output changed_count,
		output average_count, input ready);
	modport sink (input valid, input event_res, input changed_count,
		input average_count, output ready);

endinterface

// ===== hw/rtl/fdd_cfg_if.sv =====
// ----------------------------------------------------------------------------
// fdd_cfg_if
// Configuration write channel carrying the threshold register value.
// ----------------------------------------------------------------------------
interface fdd_cfg_if;
	import fdd_pkg::*;

	logic valid;
	logic ready;
	thr_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

// ===== hw/rtl/fdd_ram.sv =====
// ----------------------------------------------------------------------------
// fdd_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module fdd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 65536,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/fdd_frame.sv =====
// ----------------------------------------------------------------------------
// fdd_frame
// Frame store read-modify-write stage and change counter.
// ----------------------------------------------------------------------------
module fdd_frame #(
	parameter int FRAME_PIXELS = 65536,
	parameter int AW           = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [AW-1:0]      addr,
	input  logic               in_range,
	input  fdd_pkg::pixel_t    pixel,
	input  logic               last_pixel,
	output fdd_pkg::frame_end_t fe
);
	import fdd_pkg::*;

	logic          valid_s1;
	logic          last_s1;
	logic          in_range_s1;
	pixel_t        pixel_s1;
	logic [AW-1:0] addr_s1;
	pixel_t        prev_pixel;
	count_t        count_q;
	logic          have_ref_q;
	logic          inc;
	count_t        count_next;

	fdd_ram #(
		.WIDTH (PIXEL_W),
		.DEPTH (FRAME_PIXELS),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (valid_s1 && in_range_s1),
		.waddr (addr_s1),
		.wdata (pixel_s1),
		.re    (accept),
		.raddr (addr),
		.rdata (prev_pixel)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			count_q    <= '0;
			have_ref_q <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (valid_s1) begin
				if (last_s1) begin
					count_q    <= '0;
					have_ref_q <= 1'b1;
				end else begin
					count_q <= count_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1     <= last_pixel;
			in_range_s1 <= in_range;
			pixel_s1    <= pixel;
			addr_s1     <= addr;
		end
	end

	always_comb begin
		inc        = have_ref_q && in_range_s1 && (prev_pixel != pixel_s1)
			&& (count_q != COUNT_MAX);
		count_next = count_q + COUNT_W'(inc);
		fe.last    = valid_s1 && last_s1;
		fe.report  = valid_s1 && last_s1 && have_ref_q;
		fe.count   = count_next;
	end

endmodule

// ===== hw/rtl/fdd_stats.sv =====
// ----------------------------------------------------------------------------
// fdd_stats
// End-of-frame averaging, deviation test and result register.
// ----------------------------------------------------------------------------
module fdd_stats (
	input  logic                clk,
	input  logic                arst_n,
	input  fdd_pkg::frame_end_t fe,
	input  fdd_pkg::thr_t       thr,
	output logic                done,
	fdd_res_if.source           res
);
	import fdd_pkg::*;

	logic   valid_s2;
	count_t count_s2;
	count_t avg_s2;
	logic   nz_s2;
	logic   valid_s3;
	count_t count_s3;
	count_t avg_s3;
	logic   nz_s3;
	prod_t  dev_prod_s3;
	prod_t  thr_prod_s3;
	count_t avg_q;
	logic   out_valid_q;
	logic   event_q;
	count_t count_q;
	count_t out_avg_q;

	logic [COUNT_W:0] sum;
	count_t           avg_new;
	count_t           dev;
	logic             event_now;

	always_comb begin
		sum = {1'b0, avg_q} + {1'b0, fe.count};
		if (fe.count == '0) begin
			avg_new = avg_q;
		end else if (avg_q == '0) begin
			avg_new = fe.count;
		end else begin
			avg_new = sum[COUNT_W:1];
		end
		dev       = (avg_s2 > count_s2) ? (avg_s2 - count_s2) : (count_s2 - avg_s2);
		event_now = nz_s3 && (dev_prod_s3 > thr_prod_s3);
		done      = valid_s3 && (!out_valid_q || res.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			avg_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s2 <= fe.report;
			if (valid_s2) begin
				valid_s3 <= 1'b1;
			end else if (done) begin
				valid_s3 <= 1'b0;
			end
			if (done) begin
				avg_q       <= event_now ? '0 : avg_s3;
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fe.report) begin
			count_s2 <= fe.count;
			avg_s2   <= avg_new;
			nz_s2    <= (fe.count != '0);
		end
		if (valid_s2) begin
			count_s3    <= count_s2;
			avg_s3      <= avg_s2;
			nz_s3       <= nz_s2;
			dev_prod_s3 <= PROD_W'(dev) * PROD_W'(PERCENT_SCALE);
			thr_prod_s3 <= PROD_W'(thr) * PROD_W'(avg_s2);
		end
		if (done) begin
			event_q   <= event_now;
			count_q   <= count_s3;
			out_avg_q <= avg_s3;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.event_res     = event_q;
	assign res.changed_count = count_q;
	assign res.average_count = out_avg_q;

endmodule

// ===== hw/rtl/frame_difference_event_detector.sv =====
// ----------------------------------------------------------------------------
// frame_difference_event_detector
// Compares each frame with the stored previous one and reports change counts.
// ----------------------------------------------------------------------------
// Pixels enter on pix, one item per pixel in raster order, with last_pixel set
// on the final pixel of a frame. Each pixel is checked against the frame store
// entry at its position and then written back over it, so the store is read
// for one pixel while the pixel before it is written back.
// Ordinary pixels are taken at one per cycle. After a pixel that ends a frame
// the input pauses while the average and the deviation test are computed
// through the s2 and s3 stage registers, and until the frame report is loaded
// into the output register on res. The first frame after reset only fills the
// store, gives no report and pauses the input until its end leaves stage s1.
// Pixels past FRAME_PIXELS in a frame are ignored.
// The threshold register is written on cfg, which is always ready.
// Reset clears the counters, the average and the first-frame flag and sets
// the threshold to five percent; the frame store is not cleared.
// When res is stalled the report waits in its output register and the input
// stays paused after the next frame end until the report has been taken.
// ----------------------------------------------------------------------------
module frame_difference_event_detector #(
	parameter int FRAME_PIXELS = 65536
) (
	input  logic      clk,
	input  logic      arst_n,
	fdd_pix_if.sink   pix,
	fdd_res_if.source res,
	fdd_cfg_if.sink   cfg
);
	import fdd_pkg::*;

	localparam int AW = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
	localparam int PW = $clog2(FRAME_PIXELS + 1);

	logic [PW-1:0] pos_q;
	logic          busy_q;
	thr_t          thr_q;
	logic          accept;
	logic          in_range;
	logic          done;
	frame_end_t    fe;

	assign pix.ready = !busy_q;
	assign cfg.ready = 1'b1;
	assign accept    = pix.valid && !busy_q;
	assign in_range  = (pos_q < PW'(FRAME_PIXELS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			busy_q <= 1'b0;
			thr_q  <= THR_RESET;
		end else begin
			if (cfg.valid) begin
				thr_q <= cfg.data;
			end
			if (accept) begin
				if (pix.last_pixel) begin
					pos_q  <= '0;
					busy_q <= 1'b1;
				end else if (in_range) begin
					pos_q <= pos_q + PW'(1);
				end
			end else if ((fe.last && !fe.report) || done) begin
				busy_q <= 1'b0;
			end
		end
	end

	fdd_frame #(
		.FRAME_PIXELS (FRAME_PIXELS),
		.AW           (AW)
	) u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.addr       (pos_q[AW-1:0]),
		.in_range   (in_range),
		.pixel      (pix.pixel),
		.last_pixel (pix.last_pixel),
		.fe         (fe)
	);

	fdd_stats u_stats (
		.clk    (clk),
		.arst_n (arst_n),
		.fe     (fe),
		.thr    (thr_q),
		.done   (done),
		.res    (res)
	);

endmodule

// ===== tb/frame_difference_event_detector_tb.sv =====
// ----------------------------------------------------------------------------
// frame_difference_event_detector_tb
// Self-checking bench for the frame difference event detector.
// ----------------------------------------------------------------------------
// A table of frames comes first. The first two frames cover every position that
// any later frame reaches, so no frame reads a store entry that was never
// written. They are followed by short frames with known reports and threshold
// writes at zero, five, one hundred and the top of the register range. Then
// runs of short random frames follow, where the number of changed pixels
// drifts from frame to frame. Each pixel item is fed to a frame model that
// predicts the report at every frame end after the first, unless the table
// gives it. Reports are checked in order, with random gaps on both channels,
// one long stall of the report channel and pauses until every report has come.
// ----------------------------------------------------------------------------
module frame_difference_event_detector_tb;
	import fdd_pkg::*;

	localparam int FRAME_PIXELS = 65536;
	localparam int AW           = $clog2(FRAME_PIXELS);
	localparam int PERIOD       = 12;

	typedef enum logic [1:0] {KIND_FILL, KIND_MIXED, KIND_NOISE} frame_kind_t;

	typedef struct packed {
		logic   flag;
		count_t changed;
		count_t average;
	} report_t;

	typedef struct {
		int          len;
		frame_kind_t kind;
		pixel_t      value;
		int          thr;
		bit          typed;
		report_t     report;
	} frame_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	fdd_pix_if pix ();
	fdd_res_if res ();
	fdd_cfg_if cfg ();

	frame_difference_event_detector DUT (
		.clk(clk),
		.arst_n(arst_n),
		.pix(pix),
		.res(res),
		.cfg(cfg)
	);

	pixel_t      stored_frame [FRAME_PIXELS];
	int unsigned frame_pos = 0;
	int unsigned diff_count = 0;
	int unsigned avg_state = 0;
	bit          have_ref = 1'b0;
	thr_t        threshold = THR_RESET;

	report_t    report_q [$];
	frame_row_t plan [$];
	bit         typed_pending = 1'b0;
	report_t    typed_report;
	report_t    wanted;
	int         errors = 0;
	int         reports_seen = 0;
	int         pixels_sent = 0;
	bit         calm = 1'b0;

	always #(PERIOD / 2) clk = ~clk;

	initial begin
		#(PERIOD * 2_000_000);
		$display("simulation failed");
		$finish;
	end

	task automatic absorb_pixel(input pixel_t px, input logic last);
		report_t     r;
		int unsigned cnt;
		int unsigned mean;
		int unsigned dev;
		if (frame_pos < FRAME_PIXELS) begin
			if (have_ref && stored_frame[frame_pos[AW-1:0]] != px && diff_count < COUNT_MAX)
				diff_count++;
			stored_frame[frame_pos[AW-1:0]] = px;
			frame_pos++;
		end
		if (last) begin
			frame_pos = 0;
			if (!have_ref) begin
				have_ref = 1'b1;
				diff_count = 0;
			end else begin
				cnt = diff_count;
				diff_count = 0;
				mean = avg_state;
				r.flag = 1'b0;
				if (cnt != 0) begin
					mean = (mean == 0) ? cnt : (mean + cnt) >> 1;
					dev = (mean > cnt) ? mean - cnt : cnt - mean;
					r.flag = dev * PERCENT_SCALE > threshold * mean;
				end
				avg_state = r.flag ? 0 : mean;
				r.changed = count_t'(cnt);
				r.average = count_t'(mean);
				if (typed_pending) begin
					report_q.push_back(typed_report);
					typed_pending = 1'b0;
				end else begin
					report_q.push_back(r);
				end
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && pix.valid && pix.ready)
			absorb_pixel(pix.pixel, pix.last_pixel);
		if (arst_n && cfg.valid && cfg.ready)
			threshold = cfg.data;
	end

	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready) begin
			reports_seen++;
			if (report_q.size() == 0) begin
				$display("%0t: report with none expected: event_res %0d changed_count %0d "
					, $time, res.event_res, res.changed_count,
					"average_count %0d", res.average_count);
				errors++;
			end else begin
				wanted = report_q.pop_front();
				if (res.event_res !== wanted.flag) begin
					$display("%0t: event_res expected %0d, got %0d",
						$time, wanted.flag, res.event_res);
					errors++;
				end
				if (res.changed_count !== wanted.changed) begin
					$display("%0t: changed_count expected %0d, got %0d",
						$time, wanted.changed, res.changed_count);
					errors++;
				end
				if (res.average_count !== wanted.average) begin
					$display("%0t: average_count expected %0d, got %0d",
						$time, wanted.average, res.average_count);
					errors++;
				end
			end
		end
	end

	function automatic int unsigned gap_len();
		if ($urandom_range(99) < 80)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// The report channel stalls once for a long stretch so that the block fills up.
	initial begin
		int  stall_left;
		bit  long_hold_done;
		stall_left = 0;
		long_hold_done = 1'b0;
		res.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left == 0 && !long_hold_done && reports_seen >= 20) begin
				long_hold_done = 1'b1;
				stall_left = 300;
			end else if (stall_left == 0 && !calm && $urandom_range(99) < 12) begin
				stall_left = gap_len();
			end
			if (stall_left > 0) begin
				res.ready <= 1'b0;
				stall_left--;
			end else begin
				res.ready <= 1'b1;
			end
		end
	end

	task automatic send_pixel(input pixel_t px, input logic last);
		int unsigned gap;
		if (!calm && $urandom_range(99) < 15) begin
			gap = gap_len();
			pix.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix.valid <= 1'b1;
		pix.pixel <= px;
		pix.last_pixel <= last;
		do @(posedge clk); while (!pix.ready);
		pixels_sent++;
		@(negedge clk);
	endtask

	task automatic send_frame(input int len, input frame_kind_t kind, input pixel_t value,
		input int changes);
		pixel_t px;
		for (int i = 0; i < len; i++) begin
			case (kind)
				KIND_FILL: px = value;
				KIND_MIXED: begin
					px = stored_frame[i[AW-1:0]];
					if ($urandom_range(len - 1) < changes)
						px = px ^ pixel_t'($urandom_range(1, 255));
				end
				default: px = pixel_t'($urandom);
			endcase
			send_pixel(px, i == len - 1);
		end
	endtask

	task automatic drain(input int extra);
		pix.valid <= 1'b0;
		do @(negedge clk); while (report_q.size() != 0);
		repeat (extra) @(negedge clk);
	endtask

	task automatic write_threshold(input thr_t value);
		cfg.valid <= 1'b1;
		cfg.data <= value;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	function automatic void add_frame(input int len, input frame_kind_t kind,
		input pixel_t value, input int thr, input bit typed, input logic flag,
		input int changed, input int average);
		frame_row_t r;
		r.len = len;
		r.kind = kind;
		r.value = value;
		r.thr = thr;
		r.typed = typed;
		r.report.flag = flag;
		r.report.changed = count_t'(changed);
		r.report.average = count_t'(average);
		plan.push_back(r);
	endfunction

	initial begin
		int run_len;
		int frames;
		int changes;
		int run_index;
		int target;
		int random_frames;
		pix.valid = 1'b0;
		pix.pixel = '0;
		pix.last_pixel = 1'b0;
		cfg.valid = 1'b0;
		cfg.data = '0;

		add_frame(120, KIND_FILL, 8'h00, -1, 1'b0, 1'b0, 0, 0);
		add_frame(120, KIND_FILL, 8'hFF, -1, 1'b1, 1'b0, 120, 120);
		add_frame(4, KIND_FILL, 8'hFF, -1, 1'b1, 1'b0, 0, 120);
		add_frame(4, KIND_FILL, 8'h00, -1, 1'b1, 1'b1, 4, 62);
		add_frame(4, KIND_FILL, 8'hFF, -1, 1'b1, 1'b0, 4, 4);
		add_frame(1, KIND_FILL, 8'h80, -1, 1'b1, 1'b1, 1, 2);
		add_frame(4, KIND_FILL, 8'h7F, 100, 1'b1, 1'b0, 4, 4);
		add_frame(8, KIND_FILL, 8'h02, -1, 1'b1, 1'b0, 8, 6);
		add_frame(8, KIND_FILL, 8'h02, 0, 1'b1, 1'b0, 0, 6);
		add_frame(6, KIND_FILL, 8'h03, -1, 1'b1, 1'b0, 6, 6);
		add_frame(7, KIND_FILL, 8'h04, -1, 1'b1, 1'b1, 7, 6);
		add_frame(12, KIND_NOISE, 8'h00, 127, 1'b0, 1'b0, 0, 0);
		add_frame(12, KIND_MIXED, 8'h00, -1, 1'b0, 1'b0, 6, 0);
		add_frame(12, KIND_MIXED, 8'h00, 5, 1'b0, 1'b0, 1, 0);

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[k]) begin
			if (plan[k].thr >= 0) begin
				drain(10);
				write_threshold(thr_t'(plan[k].thr));
			end
			typed_pending = plan[k].typed;
			typed_report = plan[k].report;
			calm = plan[k].len > 1000;
			send_frame(plan[k].len, plan[k].kind, plan[k].value,
				int'(plan[k].report.changed));
		end
		calm = 1'b0;

		run_index = 0;
		random_frames = 0;
		target = 900;
		while (pixels_sent < target || random_frames < 20) begin
			run_index++;
			run_len = ($urandom_range(9) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 24);
			frames = $urandom_range(2, 8);
			if (run_index % 8 == 0) begin
				drain(10);
				write_threshold(thr_t'($urandom_range(0, 127)));
			end else if (run_index % 5 == 0) begin
				drain(0);
			end
			calm = ($urandom_range(4) == 0);
			changes = $urandom_range(0, run_len);
			repeat (frames) begin
				if ($urandom_range(9) == 0) begin
					send_frame(run_len, KIND_NOISE, 8'h00, 0);
				end else begin
					if ($urandom_range(9) < 3)
						changes = $urandom_range(0, run_len);
					else
						changes = changes + int'($urandom_range(0, 2)) - 1;
					if (changes < 0)
						changes = 0;
					if (changes > run_len)
						changes = run_len;
					send_frame(run_len, KIND_MIXED, 8'h00, changes);
				end
				random_frames++;
			end
		end
		calm = 1'b0;

		drain(20);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
